// ===== hdl/asbf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asbf_pkg
// shared types and constants for the auto-range sample batch framer
// ----------------------------------------------------------------------------

package asbf_pkg;

    // field widths
    localparam int READING_W  = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;
    localparam int RANGE_W    = 2;
    localparam int NUM_GAINS  = 4;
    localparam int GAIN_IDX_W = 2;
    localparam int SEQ_W      = 8;
    localparam int RUN_W      = 16;

    // frame layout
    localparam logic [31:0] FRAME_CODE = 32'h0100_0C32;
    localparam int HDR_LEN    = 11;
    localparam int CODE_BYTES = 4;
    localparam int POS_SEQ    = 4;
    localparam int POS_CHAN   = 6;
    localparam int POS_COUNT  = 7;

    // byte phases within one sample
    localparam logic [1:0] PH_LO    = 2'd0;
    localparam logic [1:0] PH_HI    = 2'd1;
    localparam logic [1:0] PH_RANGE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    // register reset values
    localparam logic [RUN_W-1:0]     RESET_RUN_LEN = 16'd1;
    localparam logic [READING_W-1:0] RESET_LIMIT   = 16'd64000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [RANGE_W-1:0]   range_idx;
        logic [READING_W-1:0] value;
    } batch_entry_t;

endpackage

`default_nettype wire

// ===== hdl/asbf_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asbf_in_if
// sample channel: four gain-step readings per transaction
// ----------------------------------------------------------------------------

interface asbf_in_if
    import asbf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [READING_W-1:0] reading_gain_low;
    logic [READING_W-1:0] reading_gain_mid;
    logic [READING_W-1:0] reading_gain_high;
    logic [READING_W-1:0] reading_gain_top;

    modport source
    (
        output valid,
        output reading_gain_low,
        output reading_gain_mid,
        output reading_gain_high,
        output reading_gain_top,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  reading_gain_low,
        input  reading_gain_mid,
        input  reading_gain_high,
        input  reading_gain_top,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/asbf_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asbf_out_if
// frame byte channel: one byte and an end flag per transaction
// ----------------------------------------------------------------------------

interface asbf_out_if
    import asbf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;

    modport source
    (
        output valid,
        output frame_byte,
        output frame_end,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  frame_byte,
        input  frame_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/autorange_sample_batch_framer.sv =====
`default_nettype none
// range pick: one compare a cycle, top gain first, until a reading is within the limit
//   or the lowest gain is reached; ST_EMIT then loads the frame bytes into the output register
// frames: 11 + 3*n bytes, one byte a cycle through the output register while the sink
//   is ready; no new sample is taken until the scan and any frame are finished
// reset: async active low; counters cleared, registers to channel 0, run 1, limit 64000
// ----------------------------------------------------------------------------
// autorange_sample_batch_framer
// picks the highest unsaturated gain reading per sample, batches the kept
// samples and sends each batch as a little-endian byte frame
// ----------------------------------------------------------------------------

module autorange_sample_batch_framer
    import asbf_pkg::*;
#(
    parameter int BATCH_SIZE = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    asbf_in_if.sink              samp_in,
    asbf_out_if.source           frame_out
);

    // derived sizes
    localparam int IDX_W  = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int FILL_W = $clog2(BATCH_SIZE + 1);
    localparam int POS_W  = $clog2(HDR_LEN + 3 * BATCH_SIZE);
    localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(BATCH_SIZE - 1);

    // sequencer
    state_t state_reg;
    state_t state_next;

    // configuration
    logic                 chan_reg;
    logic [RUN_W-1:0]     run_len_reg;
    logic [READING_W-1:0] limit_reg;

    // captured readings, indexed by gain step (0 = lowest gain)
    logic [READING_W-1:0]  reading_reg [NUM_GAINS];
    logic [GAIN_IDX_W-1:0] gain_reg;

    // batch store
    batch_entry_t batch_mem [BATCH_SIZE];
    batch_entry_t samp_q_reg;
    batch_entry_t new_entry;

    // per-run counters
    logic [FILL_W-1:0] fill_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [RUN_W-1:0]  run_idx_reg;

    // frame emission
    logic              last_run_reg;
    logic [FILL_W-1:0] count_reg;
    logic [FILL_W-1:0] count_next;
    logic [POS_W-1:0]  end_pos_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  smp_reg;
    logic [IDX_W-1:0]  smp_next;
    logic [1:0]        ph_reg;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_end_reg;

    // control
    logic              in_ready;
    logic              accept_in;
    logic              scan_hit;
    logic              scan_done;
    logic              run_end;
    logic              batch_full;
    logic              emit_frame;
    logic              out_load;
    logic              frame_done;
    logic              in_payload;
    logic [BYTE_W-1:0] byte_value;

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = emit_frame ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (frame_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer outputs and the shared compare
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept_in = in_ready && samp_in.valid;

        // one comparator, walked from the top gain down to the lowest
        scan_hit  = (reading_reg[gain_reg] <= limit_reg);
        scan_done = (state_reg == ST_SCAN) && (scan_hit || (gain_reg == '0));

        // the lowest gain is kept with range 3 whether or not it is in range
        new_entry.value     = reading_reg[gain_reg];
        new_entry.range_idx = RANGE_W'(NUM_GAINS - 1) - RANGE_W'(gain_reg);

        // run end compare wraps at 16 bits, so a zero length is 65536 samples
        run_end    = (run_idx_reg == (run_len_reg - RUN_W'(1)));
        batch_full = (fill_reg == LAST_SLOT);
        emit_frame = batch_full || run_end;
        count_next = fill_reg + FILL_W'(1);

        // output register reloads in ST_EMIT whenever it is empty or being drained
        out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || frame_out.ready);
        frame_done = out_load && (pos_reg == end_pos_reg);
        in_payload = (pos_reg >= POS_W'(HDR_LEN));

        // sample index for the registered batch read, one step ahead
        smp_next = smp_reg;
        if (scan_done)
        begin
            smp_next = '0;
        end
        else if (out_load && !frame_done && in_payload && (ph_reg == PH_RANGE))
        begin
            smp_next = smp_reg + IDX_W'(1);
        end

        // byte selection
        byte_value = '0;
        if (in_payload)
        begin
            case (ph_reg)
                PH_LO:    byte_value = samp_q_reg.value[7:0];
                PH_HI:    byte_value = samp_q_reg.value[15:8];
                PH_RANGE: byte_value = BYTE_W'(samp_q_reg.range_idx);
                default:  byte_value = '0;
            endcase
        end
        else if (pos_reg < POS_W'(CODE_BYTES))
        begin
            byte_value = FRAME_CODE[{pos_reg[1:0], 3'b000} +: BYTE_W];
        end
        else if (pos_reg == POS_W'(POS_SEQ))
        begin
            byte_value = seq_reg;
        end
        else if (pos_reg == POS_W'(POS_CHAN))
        begin
            byte_value = BYTE_W'(chan_reg);
        end
        else if (pos_reg == POS_W'(POS_COUNT))
        begin
            byte_value = BYTE_W'(count_reg);
        end
    end

    assign samp_in.ready        = in_ready;
    assign frame_out.valid      = out_valid_reg;
    assign frame_out.frame_byte = out_byte_reg;
    assign frame_out.frame_end  = out_end_reg;

    // ------------------------------------------------------------------------
    // configuration registers; unknown indexes are dropped
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg    <= 1'b0;
            run_len_reg <= RESET_RUN_LEN;
            limit_reg   <= RESET_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CHANNEL: chan_reg    <= cfg_wr_data[0];
                CFG_RUN_LEN: run_len_reg <= cfg_wr_data[RUN_W-1:0];
                CFG_LIMIT:   limit_reg   <= cfg_wr_data[READING_W-1:0];
                default:
                begin
                    chan_reg <= chan_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // reading capture and gain walk
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            reading_reg[0] <= samp_in.reading_gain_low;
            reading_reg[1] <= samp_in.reading_gain_mid;
            reading_reg[2] <= samp_in.reading_gain_high;
            reading_reg[3] <= samp_in.reading_gain_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else if (accept_in)
        begin
            gain_reg <= GAIN_IDX_W'(NUM_GAINS - 1);
        end
        else if ((state_reg == ST_SCAN) && !scan_done)
        begin
            gain_reg <= gain_reg - GAIN_IDX_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // batch store: written at the fill slot, read registered for emission
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            batch_mem[fill_reg[IDX_W-1:0]] <= new_entry;
        end
    end

    // reread every cycle, so a slot written as the frame starts is seen
    // well before the header is out
    always_ff @(posedge clk)
    begin
        samp_q_reg <= batch_mem[smp_next];
    end

    // ------------------------------------------------------------------------
    // run counters and frame position
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            seq_reg      <= '0;
            run_idx_reg  <= '0;
            last_run_reg <= 1'b0;
            count_reg    <= '0;
            end_pos_reg  <= '0;
            pos_reg      <= '0;
            smp_reg      <= '0;
            ph_reg       <= PH_LO;
        end
        else
        begin
            smp_reg <= smp_next;
            if (scan_done)
            begin
                if (emit_frame)
                begin
                    // frame length is 11 + 3n bytes
                    count_reg    <= count_next;
                    end_pos_reg  <= POS_W'(HDR_LEN - 1) + (POS_W'(count_next) << 1)
                                    + POS_W'(count_next);
                    last_run_reg <= run_end;
                    pos_reg      <= '0;
                    ph_reg       <= PH_LO;
                end
                else
                begin
                    fill_reg    <= count_next;
                    run_idx_reg <= run_idx_reg + RUN_W'(1);
                end
            end
            else if (out_load)
            begin
                if (frame_done)
                begin
                    fill_reg <= '0;
                    if (last_run_reg)
                    begin
                        // run over: the next sample opens a fresh run
                        seq_reg     <= '0;
                        run_idx_reg <= '0;
                    end
                    else
                    begin
                        seq_reg     <= seq_reg + SEQ_W'(1);
                        run_idx_reg <= run_idx_reg + RUN_W'(1);
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                    if (in_payload)
                    begin
                        ph_reg <= (ph_reg == PH_RANGE) ? PH_LO : ph_reg + 2'd1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= byte_value;
            out_end_reg  <= frame_done;
        end
    end

`ifndef SYNTHESIS
    a_fill_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_SLOT)
        else $error("batch fill beyond last slot");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg <= end_pos_reg))
        else $error("frame position past frame end");

    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (state_reg == ST_IDLE) && (fill_reg == '0) && out_end_reg)
        else $error("frame did not close cleanly");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (gain_reg == '0)) |=> (state_reg != ST_SCAN))
        else $error("gain walk ran past the lowest gain");
`endif

endmodule

`default_nettype wire
